@@ sv/hclr_pkg.sv @@
// Package with shared types, constants and the HSL classification function.
package hclr_pkg;

    localparam int unsigned HueW = 9;
    localparam int unsigned TenW = 4;
    localparam int unsigned ChW = 8;
    localparam int unsigned ClsW = 2;

    localparam logic [HueW-1:0] YelLoRst = 9'd50;
    localparam logic [HueW-1:0] YelHiRst = 9'd65;
    localparam logic [HueW-1:0] BluLoRst = 9'd220;
    localparam logic [HueW-1:0] BluHiRst = 9'd250;
    localparam logic [TenW-1:0] SatRst = 4'd3;
    localparam logic [TenW-1:0] LightLoRst = 4'd2;
    localparam logic [TenW-1:0] LightHiRst = 4'd8;

    localparam logic [ClsW-1:0] ClsKeep = 2'd0;
    localparam logic [ClsW-1:0] ClsYellow = 2'd1;
    localparam logic [ClsW-1:0] ClsBlue = 2'd2;

    localparam logic [2:0] RegYelLo = 3'd0;
    localparam logic [2:0] RegYelHi = 3'd1;
    localparam logic [2:0] RegBluLo = 3'd2;
    localparam logic [2:0] RegBluHi = 3'd3;
    localparam logic [2:0] RegSat = 3'd4;
    localparam logic [2:0] RegLightLo = 3'd5;
    localparam logic [2:0] RegLightHi = 3'd6;

    typedef struct packed {
        logic [HueW-1:0] yel_lo;
        logic [HueW-1:0] yel_hi;
        logic [HueW-1:0] blu_lo;
        logic [HueW-1:0] blu_hi;
        logic [TenW-1:0] sat;
        logic [TenW-1:0] light_lo;
        logic [TenW-1:0] light_hi;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_yel;
        logic overflow;
        logic hit;
        logic scan_last;
    } t_sts;

    typedef struct packed {
        logic hue_y;
        logic hue_b;
        logic sl_ok;
    } t_cls;

    function automatic t_cls classify(input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                                      input logic [ChW-1:0] b, input t_cfg c);
        logic [ChW-1:0] mx;
        logic [ChW-1:0] mn;
        logic [ChW-1:0] d;
        logic signed [17:0] n;
        logic signed [18:0] ly;
        logic signed [18:0] hy;
        logic signed [18:0] lb;
        logic signed [18:0] hb;
        logic [ChW:0] sum;
        logic [ChW:0] den;
        t_cls o;
        mx = (r >= g) ? r : g;
        mx = (mx >= b) ? mx : b;
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        d = mx - mn;
        if (mx == r) begin
            n = 18'sd60 * ($signed({10'd0, g}) - $signed({10'd0, b}))
                + ((g < b) ? 18'sd360 * $signed({10'd0, d}) : 18'sd0);
        end else if (mx == g) begin
            n = 18'sd60 * ($signed({10'd0, b}) - $signed({10'd0, r}))
                + 18'sd120 * $signed({10'd0, d});
        end else begin
            n = 18'sd60 * ($signed({10'd0, r}) - $signed({10'd0, g}))
                + 18'sd240 * $signed({10'd0, d});
        end
        ly = $signed({2'd0, 17'(c.yel_lo * d)});
        hy = $signed({2'd0, 17'(c.yel_hi * d)});
        lb = $signed({2'd0, 17'(c.blu_lo * d)});
        hb = $signed({2'd0, 17'(c.blu_hi * d)});
        if (d == '0) begin
            o.hue_y = (c.yel_lo == '0);
            o.hue_b = (c.blu_lo == '0);
        end else begin
            o.hue_y = (ly <= 19'(n)) && (19'(n) <= hy);
            o.hue_b = (lb <= 19'(n)) && (19'(n) <= hb);
        end
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum <= 9'd255) ? sum : 9'(10'd510 - {1'b0, sum});
        o.sl_ok = ({1'b0, sum} >= 10'(c.light_lo * 6'd51))
               && ({1'b0, sum} <= 10'(c.light_hi * 6'd51))
               && (sum != '0)
               && (12'(d * 4'd10) > 13'(c.sat * den));
        return o;
    endfunction

    function automatic logic [21:0] luma(input logic [ChW-1:0] r, input logic [ChW-1:0] g,
                                         input logic [ChW-1:0] b);
        return 22'(r * 12'd2126) + 22'(g * 13'd7152) + 22'(b * 10'd722);
    endfunction

endpackage

@@ sv/hclr_ctrl.sv @@
// Controller state machine that sequences classification and the candidate scan.
module hclr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output hclr_pkg::t_cmd o_cmd,
    input  hclr_pkg::t_sts i_sts
);
    import hclr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.is_yel && i_sts.overflow) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit || i_sts.scan_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ sv/hclr_dp.sv @@
// Datapath with pixel registers, classification and the candidate scan counters.
module hclr_dp (
    input  logic                    i_clk,
    input  hclr_pkg::t_cfg          i_cfg,
    input  logic [hclr_pkg::ChW-1:0] i_red,
    input  logic [hclr_pkg::ChW-1:0] i_green,
    input  logic [hclr_pkg::ChW-1:0] i_blue,
    input  hclr_pkg::t_cmd          i_cmd,
    output hclr_pkg::t_sts          o_sts,
    output logic [hclr_pkg::ChW-1:0] o_red,
    output logic [hclr_pkg::ChW-1:0] o_green,
    output logic [hclr_pkg::ChW-1:0] o_blue,
    output logic [hclr_pkg::ClsW-1:0] o_cls
);
    import hclr_pkg::*;

    logic [ChW-1:0] r_r, r_g, r_b;
    logic [ChW-1:0] r_i, r_j, r_k;
    logic [ChW-1:0] r_rs, r_gs, r_bs;
    logic [22:0] r_target;
    logic [ChW-1:0] r_ro, r_go, r_bo;
    logic [ClsW-1:0] r_cls;
    t_cls c_in, c_sc;
    logic [22:0] cand_l;
    logic low, yel, k_end, j_end;
    logic in_yel, hit;

    assign c_in = classify(r_r, r_g, r_b, i_cfg);
    assign c_sc = classify(r_i, r_j, r_k, i_cfg);
    assign cand_l = {1'b0, luma(r_i, r_j, r_k)};
    assign low = cand_l < r_target;
    assign yel = c_sc.hue_y && c_sc.sl_ok;
    assign k_end = low || (r_k == r_bs);
    assign j_end = (r_j == r_gs);
    assign in_yel = c_in.hue_y && c_in.sl_ok;
    assign hit = !low && yel;

    assign o_sts = {in_yel, r_r[ChW-1] | r_g[ChW-1] | r_b[ChW-1], hit,
                    k_end && j_end && (r_i == r_rs)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r <= i_red;
            r_g <= i_green;
            r_b <= i_blue;
        end
        if (i_cmd.scan_start) begin
            r_i <= '1;
            r_j <= '1;
            r_k <= '1;
            r_rs <= r_r[ChW-1] ? '1 : {r_r[ChW-2:0], 1'b0};
            r_gs <= r_g[ChW-1] ? '1 : {r_g[ChW-2:0], 1'b0};
            r_bs <= r_b[ChW-1] ? '1 : {r_b[ChW-2:0], 1'b0};
            r_target <= {luma(r_r, r_g, r_b), 1'b0};
        end else if (i_cmd.scan_step) begin
            if (k_end) begin
                r_k <= '1;
                if (j_end) begin
                    r_j <= '1;
                    r_i <= r_i - 1'b1;
                end else begin
                    r_j <= r_j - 1'b1;
                end
            end else begin
                r_k <= r_k - 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_cls <= '1;
        end else if (r_cls == '1) begin
            if (in_yel) begin
                r_cls <= ClsYellow;
                r_ro <= {r_r[ChW-2:0], 1'b0};
                r_go <= {r_g[ChW-2:0], 1'b0};
                r_bo <= {r_b[ChW-2:0], 1'b0};
            end else if (c_in.hue_b && c_in.sl_ok) begin
                r_cls <= ClsBlue;
                r_ro <= {1'b0, r_r[ChW-1:1]};
                r_go <= {1'b0, r_g[ChW-1:1]};
                r_bo <= {1'b0, r_b[ChW-1:1]};
            end else begin
                r_cls <= ClsKeep;
                r_ro <= r_r;
                r_go <= r_g;
                r_bo <= r_b;
            end
        end else if (i_cmd.scan_step && hit) begin
            r_ro <= r_i;
            r_go <= r_j;
            r_bo <= r_k;
        end
    end

    assign o_red = r_ro;
    assign o_green = r_go;
    assign o_blue = r_bo;
    assign o_cls = r_cls;
endmodule

@@ sv/hsl_color_key_recolor.sv @@
// Top level of the HSL color key recolor block with its register file.
// One item at a time. For unchanged, blue and non-overflowing yellow pixels the
// result is valid in the output state, which follows the evaluate state after
// acceptance. A yellow pixel whose doubled channel passes 255 runs a downward
// candidate scan, one candidate per cycle, which ends at the first hit or after
// the last candidate. A valid result is held until it is taken.
module hsl_color_key_recolor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [1:0]  o_pixel_class,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hclr_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{YelLoRst, YelHiRst, BluLoRst, BluHiRst, SatRst, LightLoRst, LightHiRst};
        end else if (psel && penable && pwrite) begin
            case (idx)
                RegYelLo: r_cfg.yel_lo <= pwdata[HueW-1:0];
                RegYelHi: r_cfg.yel_hi <= pwdata[HueW-1:0];
                RegBluLo: r_cfg.blu_lo <= pwdata[HueW-1:0];
                RegBluHi: r_cfg.blu_hi <= pwdata[HueW-1:0];
                RegSat: r_cfg.sat <= pwdata[TenW-1:0];
                RegLightLo: r_cfg.light_lo <= pwdata[TenW-1:0];
                RegLightHi: r_cfg.light_hi <= pwdata[TenW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            RegYelLo: prdata = 32'(r_cfg.yel_lo);
            RegYelHi: prdata = 32'(r_cfg.yel_hi);
            RegBluLo: prdata = 32'(r_cfg.blu_lo);
            RegBluHi: prdata = 32'(r_cfg.blu_hi);
            RegSat: prdata = 32'(r_cfg.sat);
            RegLightLo: prdata = 32'(r_cfg.light_lo);
            RegLightHi: prdata = 32'(r_cfg.light_hi);
            default: prdata = '0;
        endcase
    end

    hclr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_in_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .o_cmd(cmd), .i_sts(sts)
    );

    hclr_dp u_dp (
        .i_clk(i_clk), .i_cfg(r_cfg), .i_red(i_red_in), .i_green(i_green_in),
        .i_blue(i_blue_in), .i_cmd(cmd), .o_sts(sts), .o_red(o_red_out),
        .o_green(o_green_out), .o_blue(o_blue_out), .o_cls(o_pixel_class)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid both high");
    a_out_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_class == ClsKeep || o_pixel_class == ClsYellow
                     || o_pixel_class == ClsBlue)) else $error("bad class");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_red_out)) else $error("result lost");
endmodule

@@ dv/tb_hsl_color_key_recolor.sv @@
// Self-checking testbench for the HSL color key recolor block.
`timescale 1ns / 1ps

module tb_hsl_color_key_recolor;
    import hclr_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] cls;
    } t_pix_out;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        bit         typed;
        t_pix_out   want;
    } t_row;

    localparam int WatchLimit = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_red_in;
    logic [7:0]  i_green_in;
    logic [7:0]  i_blue_in;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic [1:0]  o_pixel_class;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hsl_color_key_recolor dut (.*);

    int yel_lo, yel_hi, blu_lo, blu_hi, sat_floor, light_lo, light_hi;
    t_pix_out recolor_q[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    int  hold_req = 0;
    t_row rows[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit hue_match(int r, int g, int b, int lo, int hi);
        int mx, mn, d, n;
        mx = (r >= g) ? r : g;
        mx = (mx >= b) ? mx : b;
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        d = mx - mn;
        if (d == 0) return lo == 0;
        if (mx == r) n = 60 * (g - b) + ((g < b) ? 360 * d : 0);
        else if (mx == g) n = 60 * (b - r) + 120 * d;
        else n = 60 * (r - g) + 240 * d;
        return (lo * d <= n) && (n <= hi * d);
    endfunction

    function automatic bit tone_match(int r, int g, int b);
        int mx, mn, sum, den;
        mx = (r >= g) ? r : g;
        mx = (mx >= b) ? mx : b;
        mn = (r <= g) ? r : g;
        mn = (mn <= b) ? mn : b;
        sum = mx + mn;
        if (sum < light_lo * 51 || sum > light_hi * 51 || sum == 0) return 0;
        den = (sum <= 255) ? sum : 510 - sum;
        return 10 * (mx - mn) > sat_floor * den;
    endfunction

    function automatic bit yellow_pix(int r, int g, int b);
        return hue_match(r, g, b, yel_lo, yel_hi) && tone_match(r, g, b);
    endfunction

    function automatic int luminance(int r, int g, int b);
        return 2126 * r + 7152 * g + 722 * b;
    endfunction

    function automatic t_pix_out recolor(int r, int g, int b);
        int ro, go, bo, target;
        bit found;
        t_pix_out o;
        ro = r; go = g; bo = b;
        o.cls = ClsKeep;
        if (yellow_pix(r, g, b)) begin
            o.cls = ClsYellow;
            target = 2 * luminance(r, g, b);
            ro = 2 * r; go = 2 * g; bo = 2 * b;
            if (ro > 255 || go > 255 || bo > 255) begin
                found = 0;
                for (int i = 255; i >= ((ro < 255) ? ro : 255) && !found; i--) begin
                    for (int j = 255; j >= ((go < 255) ? go : 255) && !found; j--) begin
                        for (int k = 255; k >= ((bo < 255) ? bo : 255); k--) begin
                            if (luminance(i, j, k) < target) break;
                            if (yellow_pix(i, j, k)) begin
                                ro = i; go = j; bo = k;
                                found = 1;
                                break;
                            end
                        end
                    end
                end
            end
        end else if (hue_match(r, g, b, blu_lo, blu_hi) && tone_match(r, g, b)) begin
            o.cls = ClsBlue;
            ro = r / 2; go = g / 2; bo = b / 2;
        end
        o.red = ro[7:0];
        o.green = go[7:0];
        o.blue = bo[7:0];
        return o;
    endfunction

    task automatic reg_write(logic [2:0] idx, int val);
        @(negedge i_clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            RegYelLo: yel_lo = val & 'h1ff;
            RegYelHi: yel_hi = val & 'h1ff;
            RegBluLo: blu_lo = val & 'h1ff;
            RegBluHi: blu_hi = val & 'h1ff;
            RegSat: sat_floor = val & 'hf;
            RegLightLo: light_lo = val & 'hf;
            RegLightHi: light_hi = val & 'hf;
            default: ;
        endcase
    endtask

    task automatic set_all(int ylo, int yhi, int blo, int bhi, int s, int llo, int lhi);
        wait (recolor_q.size() == 0);
        repeat (10) @(posedge i_clk);
        reg_write(RegYelLo, ylo);
        reg_write(RegYelHi, yhi);
        reg_write(RegBluLo, blo);
        reg_write(RegBluHi, bhi);
        reg_write(RegSat, s);
        reg_write(RegLightLo, llo);
        reg_write(RegLightHi, lhi);
    endtask

    // The valid line is only lowered when a gap is taken, so it stays high
    // across back-to-back items.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit typed,
                              t_pix_out want);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        do @(posedge i_clk); while (!o_ready);
        recolor_q.push_back(typed ? want : recolor(r, g, b));
    endtask

    task automatic random_pixels(int count);
        int r, g, b;
        t_pix_out none;
        none = '0;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 255);
            if ($urandom_range(0, 1)) begin
                g = r - $urandom_range(0, r / 4);
                b = $urandom_range(0, r / 3);
            end else if ($urandom_range(0, 2) == 0) begin
                b = r;
                r = $urandom_range(0, b / 4);
                g = $urandom_range(0, b / 2);
            end else begin
                g = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            send_pixel(8'(r), 8'(g), 8'(b), 0, none);
        end
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    function automatic void add_row(int r, int g, int b, bit typed, int ro, int go, int bo,
                                    logic [1:0] c);
        t_row row;
        row.red = 8'(r);
        row.green = 8'(g);
        row.blue = 8'(b);
        row.typed = typed;
        row.want = {8'(ro), 8'(go), 8'(bo), c};
        rows.push_back(row);
    endfunction

    always @(negedge i_clk) begin
        static int stall_left = 0;
        logic nxt;
        if (hold_req > 0) begin
            nxt = 0;
            hold_req = hold_req - 1;
        end else if (quiet) begin
            nxt = 1;
        end else if (stall_left > 0) begin
            nxt = 0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            nxt = 0;
            stall_left = $urandom_range(0, 6);
        end else begin
            nxt = 1;
        end
        i_ready <= nxt;
    end

    always @(posedge i_clk) begin
        t_pix_out got, exp_pix;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_red_out, o_green_out, o_blue_out, o_pixel_class};
            if (recolor_q.size() == 0) begin
                if (mismatches < 10) $display("Unexpected item: %h", got);
                mismatches++;
            end else begin
                exp_pix = recolor_q.pop_front();
                if (got !== exp_pix) begin
                    if (mismatches < 10)
                        $display({"Mismatch: expected rgb %0d %0d %0d class %0d, ",
                                  "got %0d %0d %0d class %0d"},
                                 exp_pix.red, exp_pix.green, exp_pix.blue, exp_pix.cls,
                                 got.red, got.green, got.blue, got.cls);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_red_in = 0;
        i_green_in = 0;
        i_blue_in = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        yel_lo = YelLoRst;
        yel_hi = YelHiRst;
        blu_lo = BluLoRst;
        blu_hi = BluHiRst;
        sat_floor = SatRst;
        light_lo = LightLoRst;
        light_hi = LightHiRst;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        add_row(0, 0, 0, 1, 0, 0, 0, ClsKeep);
        add_row(255, 255, 255, 1, 255, 255, 255, ClsKeep);
        add_row(128, 128, 128, 1, 128, 128, 128, ClsKeep);
        add_row(0, 0, 255, 1, 0, 0, 127, ClsBlue);
        add_row(120, 110, 0, 1, 240, 220, 0, ClsYellow);
        add_row(255, 0, 0, 1, 255, 0, 0, ClsKeep);
        add_row(0, 255, 0, 1, 0, 255, 0, ClsKeep);
        add_row(255, 255, 0, 0, 0, 0, 0, ClsKeep);
        add_row(200, 200, 0, 0, 0, 0, 0, ClsKeep);
        add_row(0, 255, 255, 0, 0, 0, 0, ClsKeep);
        add_row(255, 0, 255, 0, 0, 0, 0, ClsKeep);
        add_row(200, 180, 40, 0, 0, 0, 0, ClsKeep);
        add_row(140, 120, 10, 0, 0, 0, 0, ClsKeep);
        add_row(30, 60, 200, 0, 0, 0, 0, ClsKeep);
        add_row(1, 1, 0, 0, 0, 0, 0, ClsKeep);
        add_row(254, 1, 128, 0, 0, 0, 0, ClsKeep);
        foreach (rows[i])
            send_pixel(rows[i].red, rows[i].green, rows[i].blue, rows[i].typed, rows[i].want);
        @(negedge i_clk);
        i_valid <= 0;

        set_all(0, 360, 0, 360, 0, 0, 10);
        random_pixels(25);
        set_all(300, 10, 511, 511, 15, 15, 15);
        random_pixels(15);
        set_all(40, 70, 200, 260, 1, 1, 9);
        hold_req = 60;
        random_pixels(30);
        quiet = 1;
        random_pixels(30);

        wait (recolor_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && recolor_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ hsl_color_key_recolor.f @@
sv/hclr_pkg.sv
sv/hclr_ctrl.sv
sv/hclr_dp.sv
sv/hsl_color_key_recolor.sv
dv/tb_hsl_color_key_recolor.sv
